// ----- design/hyp1f2_pkg.sv -----
// Shared types, operation codes and constants for the 1F2 series evaluator.
package hyp1f2_pkg;

   typedef logic [63:0] dbl_type;

   // Operation codes of the shared floating-point unit.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_A     = 3'd0;
   localparam logic [2:0] CSR_B1    = 3'd1;
   localparam logic [2:0] CSR_B2    = 3'd2;
   localparam logic [2:0] CSR_LIMIT = 3'd3;
   localparam logic [2:0] CSR_TOL   = 3'd4;

   localparam dbl_type ONE_BITS       = 64'h3FF0_0000_0000_0000;
   localparam dbl_type MINUS_ONE_BITS = 64'hBFF0_0000_0000_0000;
   localparam logic [10:0] LIMIT_MAX  = 11'd1024;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
      dbl_type    a;
      dbl_type    b;
   } fpu_req_type;

   typedef struct packed {
      logic    done;
      dbl_type res;
   } fpu_rsp_type;

   typedef struct packed {
      dbl_type     a;
      dbl_type     b1;
      dbl_type     b2;
      logic [10:0] term_limit;
      dbl_type     tol;
   } cfg_type;

   // Exact conversion of a nonzero 10-bit count to a double.
   function automatic dbl_type int_to_dbl(input logic [9:0] n);
      logic [3:0]  pos;
      logic [51:0] frac;
      logic [10:0] ex;
      pos = '0;
      for (int i = 0; i < 10; i++) begin
         if (n[i]) pos = 4'(i);
      end
      frac = {42'b0, n} << (6'd52 - {2'b0, pos});
      ex   = 11'd1023 + {7'b0, pos};
      return {1'b0, ex, frac};
   endfunction

endpackage

// ----- design/hyp1f2_fpu.sv -----
// Shared multi-cycle double-precision add, multiply and divide unit.
module hyp1f2_fpu
   import hyp1f2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fpu_req_type req,
   output fpu_rsp_type rsp
);

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_PRE   = 3'd1;
   localparam logic [2:0] F_ALIGN = 3'd2;
   localparam logic [2:0] F_MUL   = 3'd3;
   localparam logic [2:0] F_DIV   = 3'd4;
   localparam logic [2:0] F_NORM  = 3'd5;
   localparam logic [2:0] F_ROUND = 3'd6;

   localparam dbl_type NAN_INVALID = 64'hFFF8_0000_0000_0000;
   localparam dbl_type NAN_ZERO_DIV = 64'h7FF8_0000_0000_0000;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic               sa_ff, sa_in, sb_ff, sb_in;
   logic signed [13:0] ea_ff, ea_in, eb_ff, eb_in, e_ff, e_in;
   logic [52:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [57:0]        m_ff, m_in;
   logic               sticky_ff, sticky_in, sign_ff, sign_in;
   logic [105:0]       acc_ff, acc_in;
   logic [53:0]        rem_ff, rem_in;
   logic [4:0]         cnt_ff, cnt_in;
   dbl_type            res_ff, res_in;
   logic               done_ff, done_in;

   function automatic logic is_nan(input dbl_type x);
      return (x[62:52] == 11'h7FF) && (x[51:0] != '0);
   endfunction

   function automatic logic is_inf(input dbl_type x);
      return (x[62:52] == 11'h7FF) && (x[51:0] == '0);
   endfunction

   function automatic logic is_zero(input dbl_type x);
      return x[62:0] == '0;
   endfunction

   function automatic dbl_type quiet(input dbl_type x);
      return x | 64'h0008_0000_0000_0000;
   endfunction

   // One restoring division step: {quotient bit, shifted remainder}.
   function automatic logic [54:0] div_step(input logic [53:0] r, input logic [52:0] d);
      logic        ge;
      logic [53:0] r1;
      ge = r >= {1'b0, d};
      r1 = ge ? (r - {1'b0, d}) : r;
      return {ge, r1[52:0], 1'b0};
   endfunction

   // Special operand handling
   logic    spec;
   dbl_type spec_val;
   logic    sx;

   always_comb begin
      spec     = 1'b1;
      spec_val = '0;
      sx       = req.a[63] ^ req.b[63];
      unique case (req.op)
         OP_ADD: begin
            if (is_nan(req.a)) spec_val = quiet(req.a);
            else if (is_nan(req.b)) spec_val = quiet(req.b);
            else if (is_inf(req.a) && is_inf(req.b))
               spec_val = (req.a[63] == req.b[63]) ? req.a : NAN_INVALID;
            else if (is_inf(req.a)) spec_val = req.a;
            else if (is_inf(req.b)) spec_val = req.b;
            else if (is_zero(req.a) && is_zero(req.b))
               spec_val = {req.a[63] & req.b[63], 63'b0};
            else if (is_zero(req.a)) spec_val = req.b;
            else if (is_zero(req.b)) spec_val = req.a;
            else spec = 1'b0;
         end
         OP_MUL: begin
            if (is_nan(req.a)) spec_val = quiet(req.a);
            else if (is_nan(req.b)) spec_val = quiet(req.b);
            else if ((is_inf(req.a) && is_zero(req.b)) || (is_zero(req.a) && is_inf(req.b)))
               spec_val = NAN_INVALID;
            else if (is_inf(req.a) || is_inf(req.b)) spec_val = {sx, 11'h7FF, 52'b0};
            else if (is_zero(req.a) || is_zero(req.b)) spec_val = {sx, 63'b0};
            else spec = 1'b0;
         end
         OP_DIV: begin
            if (is_nan(req.a)) spec_val = quiet(req.a);
            else if (is_zero(req.b))
               spec_val = is_zero(req.a) ? NAN_ZERO_DIV : {sx, 11'h7FF, 52'b0};
            else if (is_nan(req.b)) spec_val = quiet(req.b);
            else if (is_inf(req.a) && is_inf(req.b)) spec_val = NAN_INVALID;
            else if (is_inf(req.a)) spec_val = {sx, 11'h7FF, 52'b0};
            else if (is_inf(req.b) || is_zero(req.a)) spec_val = {sx, 63'b0};
            else spec = 1'b0;
         end
         default: spec_val = NAN_INVALID;
      endcase
   end

   // Alignment and add/subtract
   logic               a_big, sl;
   logic signed [13:0] el, es, dexp;
   logic [52:0]        ml, ms;
   logic [57:0]        big_ext, sm_ext, sm_sh, add_res;
   logic               sh_st;

   always_comb begin
      a_big   = (ea_ff > eb_ff) || ((ea_ff == eb_ff) && (ma_ff >= mb_ff));
      el      = a_big ? ea_ff : eb_ff;
      es      = a_big ? eb_ff : ea_ff;
      ml      = a_big ? ma_ff : mb_ff;
      ms      = a_big ? mb_ff : ma_ff;
      sl      = a_big ? sa_ff : sb_ff;
      dexp    = el - es;
      big_ext = {1'b0, ml, 4'b0};
      sm_ext  = {1'b0, ms, 4'b0};
      if (dexp > 14'sd60) begin
         sm_sh = '0;
         sh_st = 1'b1;
      end else begin
         sm_sh = sm_ext >> dexp[5:0];
         sh_st = |(sm_ext & ~({58{1'b1}} << dexp[5:0]));
      end
      if (sa_ff == sb_ff) add_res = big_ext + sm_sh;
      else add_res = big_ext - sm_sh - {57'b0, sh_st};
   end

   // Partial product of the 27x27 multiplier
   logic [26:0]  px, py;
   logic [53:0]  prod;
   logic [105:0] pext;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin px = ma_ff[26:0];        py = mb_ff[26:0];        end
         2'd1: begin px = ma_ff[26:0];        py = {1'b0, mb_ff[52:27]}; end
         2'd2: begin px = {1'b0, ma_ff[52:27]}; py = mb_ff[26:0];        end
         default: begin px = {1'b0, ma_ff[52:27]}; py = {1'b0, mb_ff[52:27]}; end
      endcase
      prod = px * py;
      unique case (cnt_ff[1:0])
         2'd0:    pext = {52'b0, prod};
         2'd1:    pext = {52'b0, prod} << 27;
         2'd2:    pext = {52'b0, prod} << 27;
         default: pext = {52'b0, prod} << 54;
      endcase
   end

   // Two division steps per cycle
   logic [54:0] ds1, ds2;

   always_comb begin
      ds1 = div_step(rem_ff, mb_ff);
      ds2 = div_step(ds1[53:0], mb_ff);
   end

   // Rounding to nearest even
   logic [52:0]        frac53, mant;
   logic               g, rest, up;
   logic [53:0]        s54;
   logic signed [13:0] er;

   always_comb begin
      frac53 = m_ff[56:4];
      g      = m_ff[3];
      rest   = (|m_ff[2:0]) | sticky_ff;
      up     = g & (rest | frac53[0]);
      s54    = {1'b0, frac53} + {53'b0, up};
      if (s54[53]) begin
         mant = s54[53:1];
         er   = e_ff + 14'sd1;
      end else begin
         mant = s54[52:0];
         er   = e_ff;
      end
   end

   logic [105:0] acc_sum;
   assign acc_sum = acc_ff + pext;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      e_in      = e_ff;
      m_in      = m_ff;
      sticky_in = sticky_ff;
      sign_in   = sign_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req.start) begin
               if (spec) begin
                  res_in  = spec_val;
                  done_in = 1'b1;
               end else begin
                  op_in    = req.op;
                  sa_in    = req.a[63];
                  sb_in    = req.b[63];
                  ea_in    = (req.a[62:52] == '0) ? 14'sd1 : signed'({3'b0, req.a[62:52]});
                  eb_in    = (req.b[62:52] == '0) ? 14'sd1 : signed'({3'b0, req.b[62:52]});
                  ma_in    = {req.a[62:52] != '0, req.a[51:0]};
                  mb_in    = {req.b[62:52] != '0, req.b[51:0]};
                  state_in = F_PRE;
               end
            end
         end
         F_PRE: begin
            // Subnormal operands are brought to a leading one, one bit a cycle.
            if (!ma_ff[52]) begin
               ma_in = ma_ff << 1;
               ea_in = ea_ff - 14'sd1;
            end
            if (!mb_ff[52]) begin
               mb_in = mb_ff << 1;
               eb_in = eb_ff - 14'sd1;
            end
            if (ma_ff[52] && mb_ff[52]) begin
               cnt_in    = '0;
               sticky_in = 1'b0;
               sign_in   = sa_ff ^ sb_ff;
               unique case (op_ff)
                  OP_MUL: begin
                     acc_in   = '0;
                     e_in     = ea_ff + eb_ff - 14'sd1023;
                     state_in = F_MUL;
                  end
                  OP_DIV: begin
                     rem_in   = {1'b0, ma_ff};
                     m_in     = '0;
                     e_in     = ea_ff - eb_ff + 14'sd1022;
                     state_in = F_DIV;
                  end
                  default: state_in = F_ALIGN;
               endcase
            end
         end
         F_ALIGN: begin
            m_in      = add_res;
            sticky_in = sh_st;
            sign_in   = sl;
            e_in      = el;
            state_in  = F_NORM;
         end
         F_MUL: begin
            acc_in = acc_sum;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               m_in      = acc_sum[105:48];
               sticky_in = |acc_sum[47:0];
               state_in  = F_NORM;
            end
         end
         F_DIV: begin
            rem_in = ds2[53:0];
            m_in   = {m_ff[55:0], ds1[54], ds2[54]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd28) begin
               sticky_in = ds2[53:0] != '0;
               state_in  = F_NORM;
            end
         end
         F_NORM: begin
            if (m_ff[57]) begin
               m_in      = m_ff >> 1;
               sticky_in = sticky_ff | m_ff[0];
               e_in      = e_ff + 14'sd1;
            end else if ((m_ff == '0) && !sticky_ff) begin
               // Exact cancellation gives positive zero.
               res_in   = '0;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else if (e_ff < -14'sd62) begin
               m_in      = '0;
               sticky_in = 1'b1;
               e_in      = 14'sd1;
            end else if (e_ff < 14'sd1) begin
               m_in      = m_ff >> 1;
               sticky_in = sticky_ff | m_ff[0];
               e_in      = e_ff + 14'sd1;
            end else if (!m_ff[56] && (m_ff != '0) && (e_ff > 14'sd1)) begin
               m_in = m_ff << 1;
               e_in = e_ff - 14'sd1;
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (er >= 14'sd2047) res_in = {sign_ff, 11'h7FF, 52'b0};
            else res_in = {sign_ff, mant[52] ? er[10:0] : 11'd0, mant[51:0]};
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      e_ff      <= e_in;
      m_ff      <= m_in;
      sticky_ff <= sticky_in;
      sign_ff   <= sign_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;

endmodule

// ----- design/hyp1f2_seq.sv -----
// Sequencer that walks the series terms through the shared floating-point unit.
module hyp1f2_seq
   import hyp1f2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dbl_type     z_bits,
   input  cfg_type     cfg,
   output fpu_req_type fpu_req,
   input  fpu_rsp_type fpu_rsp,
   output logic        rsp_valid,
   output dbl_type     rsp_sum_bits,
   output logic [9:0]  rsp_terms_added,
   output logic        rsp_converged
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam logic [3:0] STEP_LAST = 4'd11;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [9:0]  n_ff, n_in, added_ff, added_in;
   logic [10:0] limit_ff, limit_in;
   logic        conv_ff, conv_in;
   dbl_type     z_ff, z_in, t0_ff, t0_in, t1_ff, t1_in;
   dbl_type     num_ff, num_in, den_ff, den_in, term_ff, term_in, sum_ff, sum_in;

   dbl_type     nd;
   logic [10:0] lim_eff;
   logic        tol_hit;

   assign nd      = int_to_dbl(n_ff);
   assign lim_eff = (cfg.term_limit > LIMIT_MAX) ? LIMIT_MAX : cfg.term_limit;

   // A NaN on either side never stops the loop; a negative tolerance never does.
   assign tol_hit = !((term_ff[62:52] == 11'h7FF) && (term_ff[51:0] != '0)) &&
                    !((cfg.tol[62:52] == 11'h7FF) && (cfg.tol[51:0] != '0)) &&
                    !cfg.tol[63] && (term_ff[62:0] < cfg.tol[62:0]);

   // Operation list of one term.
   always_comb begin
      fpu_req.start = state_ff == S_ISSUE;
      fpu_req.op    = OP_ADD;
      fpu_req.a     = t0_ff;
      fpu_req.b     = MINUS_ONE_BITS;
      unique case (step_ff)
         4'd0:  begin fpu_req.a = cfg.a;   fpu_req.b = nd;             end
         4'd1:  begin fpu_req.a = t0_ff;   fpu_req.b = MINUS_ONE_BITS; end
         4'd2:  begin fpu_req.op = OP_MUL; fpu_req.a = t0_ff; fpu_req.b = z_ff; end
         4'd3:  begin fpu_req.a = cfg.b1;  fpu_req.b = nd;             end
         4'd4:  begin fpu_req.a = t0_ff;   fpu_req.b = MINUS_ONE_BITS; end
         4'd5:  begin fpu_req.a = cfg.b2;  fpu_req.b = nd;             end
         4'd6:  begin fpu_req.a = t1_ff;   fpu_req.b = MINUS_ONE_BITS; end
         4'd7:  begin fpu_req.op = OP_MUL; fpu_req.a = t0_ff; fpu_req.b = t1_ff; end
         4'd8:  begin fpu_req.op = OP_MUL; fpu_req.a = den_ff; fpu_req.b = nd; end
         4'd9:  begin fpu_req.op = OP_DIV; fpu_req.a = num_ff; fpu_req.b = den_ff; end
         4'd10: begin fpu_req.op = OP_MUL; fpu_req.a = term_ff; fpu_req.b = num_ff; end
         4'd11: begin fpu_req.a = sum_ff;  fpu_req.b = term_ff;        end
         default: begin fpu_req.a = '0;    fpu_req.b = '0;             end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      added_in = added_ff;
      limit_in = limit_ff;
      conv_in  = conv_ff;
      z_in     = z_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               z_in     = z_bits;
               term_in  = ONE_BITS;
               sum_in   = ONE_BITS;
               n_in     = 10'd1;
               step_in  = '0;
               added_in = '0;
               conv_in  = 1'b0;
               limit_in = lim_eff;
               state_in = (lim_eff <= 11'd1) ? S_OUT : S_ISSUE;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (fpu_rsp.done) begin
               unique case (step_ff)
                  4'd0, 4'd1, 4'd3, 4'd4: t0_in = fpu_rsp.res;
                  4'd5, 4'd6:             t1_in = fpu_rsp.res;
                  4'd2, 4'd9:             num_in = fpu_rsp.res;
                  4'd7, 4'd8:             den_in = fpu_rsp.res;
                  4'd10:                  term_in = fpu_rsp.res;
                  4'd11:                  sum_in = fpu_rsp.res;
                  default:                t0_in = t0_ff;
               endcase
               if (step_ff == STEP_LAST) begin
                  state_in = S_CHECK;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_CHECK: begin
            added_in = added_ff + 10'd1;
            if (tol_hit) begin
               conv_in  = 1'b1;
               state_in = S_OUT;
            end else if (({1'b0, n_ff} + 11'd1) >= limit_ff) begin
               state_in = S_OUT;
            end else begin
               n_in     = n_ff + 10'd1;
               step_in  = '0;
               state_in = S_ISSUE;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      n_ff     <= n_in;
      added_ff <= added_in;
      limit_ff <= limit_in;
      conv_ff  <= conv_in;
      z_ff     <= z_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      term_ff  <= term_in;
      sum_ff   <= sum_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_OUT;
   assign rsp_sum_bits    = sum_ff;
   assign rsp_terms_added = added_ff;
   assign rsp_converged   = conv_ff;

endmodule

// ----- design/hypergeometric_1f2_series.sv -----
// Top level of the 1F2 series evaluator: configuration registers, sequencer and FP unit.
//
// Evaluates the truncated series 1F2(a; b1, b2; z) in IEEE double precision with
// round-to-nearest-even. An item is taken when start is high and busy is low; busy
// stays high until the result has been shown. All arithmetic goes through one shared
// floating-point unit: a multiply sums four 27x27 partial products and a divide
// yields two quotient bits a cycle; an operand that is zero, infinite or NaN is
// answered by the special-operand check. Each term needs seven adds, four
// multiplies and one divide plus the stop test; subnormal operands or results and
// cancellation in an add are normalized one bit a cycle. The result is on the
// rsp_ ports for exactly one cycle with rsp_valid high and cannot be stalled.
// Configuration writes are always accepted and must only be made while busy is low.
module hypergeometric_1f2_series
   import hyp1f2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_z_bits,
   output logic        rsp_valid,
   output logic [63:0] rsp_sum_bits,
   output logic [9:0]  rsp_terms_added,
   output logic        rsp_converged,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   dbl_type     a_ff, b1_ff, b2_ff, tol_ff;
   logic [10:0] limit_ff;
   cfg_type     cfg;
   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;
   logic [10:0] lim_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= 64'hBFE0_0000_0000_0000;
         b1_ff    <= 64'h3FE8_0000_0000_0000;
         b2_ff    <= 64'h3FF4_0000_0000_0000;
         limit_ff <= 11'd100;
         tol_ff   <= 64'h3CB0_0000_0000_0000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_A:     a_ff     <= csr_data;
            CSR_B1:    b1_ff    <= csr_data;
            CSR_B2:    b2_ff    <= csr_data;
            CSR_LIMIT: limit_ff <= csr_data[10:0];
            CSR_TOL:   tol_ff   <= csr_data;
            default:   a_ff     <= a_ff;
         endcase
      end
   end

   assign cfg.a          = a_ff;
   assign cfg.b1         = b1_ff;
   assign cfg.b2         = b2_ff;
   assign cfg.term_limit = limit_ff;
   assign cfg.tol        = tol_ff;

   hyp1f2_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .z_bits          (req_z_bits),
      .cfg             (cfg),
      .fpu_req         (fpu_req),
      .fpu_rsp         (fpu_rsp),
      .rsp_valid       (rsp_valid),
      .rsp_sum_bits    (rsp_sum_bits),
      .rsp_terms_added (rsp_terms_added),
      .rsp_converged   (rsp_converged)
   );

   hyp1f2_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   assign lim_eff = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;

   a_one_cycle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_converged_has_terms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_converged |-> rsp_terms_added != 10'd0)
      else $error("converged result without any term added");

   a_limit_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_converged && (lim_eff > 11'd1) |->
         {1'b0, rsp_terms_added} == (lim_eff - 11'd1))
      else $error("term count does not match the term limit");

   a_trivial_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (lim_eff <= 11'd1) |-> rsp_terms_added == 10'd0 && !rsp_converged)
      else $error("terms added although the limit allows none");

   a_fpu_idle_when_free: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !fpu_req.start)
      else $error("arithmetic unit started while no item is in work");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the 1F2 series evaluator.
`timescale 1ns / 1ps

import hyp1f2_pkg::*;

typedef struct {
   logic [63:0] sum;
   logic [9:0]  terms;
   logic        conv;
} series_result_type;

class series_scoreboard;
   logic [63:0] a_reg, b1_reg, b2_reg, tol_reg;
   logic [10:0] limit_reg;
   series_result_type pending[$];
   int errors;

   function new();
      a_reg     = 64'hBFE0_0000_0000_0000;
      b1_reg    = 64'h3FE8_0000_0000_0000;
      b2_reg    = 64'h3FF4_0000_0000_0000;
      limit_reg = 11'd100;
      tol_reg   = 64'h3CB0_0000_0000_0000;
      errors    = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
         CSR_A:     a_reg = value;
         CSR_B1:    b1_reg = value;
         CSR_B2:    b2_reg = value;
         CSR_LIMIT: limit_reg = value[10:0];
         CSR_TOL:   tol_reg = value;
         default: ;
      endcase
   endfunction

   // Division with the block's handling of a zero denominator.
   function real ratio_div(real num, real den);
      logic [63:0] nb, db;
      nb = $realtobits(num);
      db = $realtobits(den);
      if (db[62:0] != 63'd0) return num / den;
      if (nb[62:0] > 63'h7FF0_0000_0000_0000) return $bitstoreal(nb | 64'h0008_0000_0000_0000);
      if (nb[62:0] == 63'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({nb[63] ^ db[63], 63'h7FF0_0000_0000_0000});
   endfunction

   // Works out the series for one accepted argument.
   function void note_item(logic [63:0] z_bits);
      real ar, b1r, b2r, tolr, zr, sum, term, nd, num, den;
      int unsigned lim, n;
      series_result_type r;
      ar   = $bitstoreal(a_reg);
      b1r  = $bitstoreal(b1_reg);
      b2r  = $bitstoreal(b2_reg);
      tolr = $bitstoreal(tol_reg);
      zr   = $bitstoreal(z_bits);
      sum  = 1.0;
      term = 1.0;
      lim  = (limit_reg > 11'd1024) ? 1024 : limit_reg;
      r.terms = '0;
      r.conv  = 1'b0;
      for (n = 1; n < lim; n++) begin
         nd   = real'(n);
         num  = ((ar + nd) - 1.0) * zr;
         den  = (((b1r + nd) - 1.0) * ((b2r + nd) - 1.0)) * nd;
         term = term * ratio_div(num, den);
         sum  = sum + term;
         r.terms++;
         if ($bitstoreal($realtobits(term) & 64'h7FFF_FFFF_FFFF_FFFF) < tolr) begin
            r.conv = 1'b1;
            break;
         end
      end
      r.sum = $realtobits(sum);
      pending.insert(pending.size(), r);
   endfunction

   function void check_result(logic [63:0] sum, logic [9:0] terms, logic conv);
      series_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result sum=%h terms=%0d conv=%0d", $time, sum, terms, conv);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (sum !== e.sum) begin
         $display("%0t: sum expected %h actual %h", $time, e.sum, sum);
         errors++;
      end
      if (terms !== e.terms) begin
         $display("%0t: terms_added expected %0d actual %0d", $time, e.terms, terms);
         errors++;
      end
      if (conv !== e.conv) begin
         $display("%0t: converged expected %0d actual %0d", $time, e.conv, conv);
         errors++;
      end
   endfunction
endclass

module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_z_bits = '0;
   logic        rsp_valid;
   logic [63:0] rsp_sum_bits;
   logic [9:0]  rsp_terms_added;
   logic        rsp_converged;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   series_scoreboard sb = new();
   bit no_gaps;

   hypergeometric_1f2_series u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_sum_bits, rsp_terms_added, rsp_converged);
   end

   initial begin
      #500ms;
      $display("[hypergeometric_1f2_series] ERROR");
      $finish;
   end

   task automatic send_item(logic [63:0] z);
      int gap;
      @(negedge clock);
      start = 1'b1;
      req_z_bits = z;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_item(z);
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_all(logic [63:0] a, logic [63:0] b1, logic [63:0] b2,
                          logic [10:0] lim, logic [63:0] tol);
      drain();
      write_csr(CSR_A, a);
      write_csr(CSR_B1, b1);
      write_csr(CSR_B2, b2);
      write_csr(CSR_LIMIT, {53'd0, lim});
      write_csr(CSR_TOL, tol);
   endtask

   // Well-behaved double: a quarter-step value in [-5, 5].
   function automatic logic [63:0] tame_value();
      return $realtobits((real'($urandom_range(0, 40)) - 20.0) / 4.0);
   endfunction

   function automatic logic [63:0] random_z();
      if ($urandom_range(0, 1)) return {$urandom, $urandom};
      return tame_value();
   endfunction

   initial begin
      logic [63:0] tol_pick;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extremes and special values under the reset settings.
      no_gaps = 1'b0;
      send_item(64'h0000_0000_0000_0000);
      send_item(64'h8000_0000_0000_0000);
      send_item(64'h3FF0_0000_0000_0000);
      send_item(64'hBFF0_0000_0000_0000);
      send_item(64'h7FEF_FFFF_FFFF_FFFF);
      send_item(64'h7FF0_0000_0000_0000);
      send_item(64'hFFF0_0000_0000_0000);
      send_item(64'h7FF8_0000_0000_0000);
      send_item(64'h7FF0_0000_0000_0001);
      send_item(64'h0000_0000_0000_0001);
      send_item(64'h4059_0000_0000_0000);
      send_item(64'hFFFF_FFFF_FFFF_FFFF);

      // Zero denominator at the first term, with zero, nonzero and NaN numerators.
      set_all(64'h3FF0_0000_0000_0000, 64'h0, 64'h3FF4_0000_0000_0000, 11'd5,
              64'h3D71_9799_812D_EA11);
      send_item(64'h0);
      send_item(64'h4000_0000_0000_0000);
      drain();
      write_csr(CSR_A, 64'h7FF4_0000_0000_0000);
      send_item(64'h3FF0_0000_0000_0000);

      // Limit zero, one and above the saturation point.
      set_all(64'hBFE0_0000_0000_0000, 64'h3FE8_0000_0000_0000, 64'h3FF4_0000_0000_0000,
              11'd0, 64'h3D71_9799_812D_EA11);
      send_item(64'h4008_0000_0000_0000);
      drain();
      write_csr(CSR_LIMIT, 64'd1);
      send_item(64'h4008_0000_0000_0000);
      drain();
      write_csr(CSR_LIMIT, 64'h7FF);
      send_item(64'h0);
      // Tolerance of infinity stops on the very last allowed term.
      drain();
      write_csr(CSR_LIMIT, 64'd2);
      write_csr(CSR_TOL, 64'h7FF0_0000_0000_0000);
      send_item(64'h3FF0_0000_0000_0000);
      // NaN tolerance never stops the loop.
      drain();
      write_csr(CSR_LIMIT, 64'd6);
      write_csr(CSR_TOL, 64'h7FF8_0000_0000_0000);
      send_item(64'h3FF0_0000_0000_0000);
      // Full-length run: zero tolerance with the largest limit.
      drain();
      write_csr(CSR_LIMIT, 64'd1024);
      write_csr(CSR_TOL, 64'h0);
      send_item(64'h3FF0_0000_0000_0000);

      // Back to the reset settings for a first random batch.
      set_all(64'hBFE0_0000_0000_0000, 64'h3FE8_0000_0000_0000, 64'h3FF4_0000_0000_0000,
              11'd100, 64'h3CB0_0000_0000_0000);
      for (int i = 0; i < 20; i++) begin
         if (i % 7 == 0) no_gaps = $urandom_range(0, 1);
         if (i == 10) drain();
         send_item(random_z());
      end

      // Random settings, mostly tame parameters and short limits.
      for (int p = 0; p < 7; p++) begin
         case ($urandom_range(0, 3))
            0: tol_pick = {$urandom, $urandom};
            1: tol_pick = 64'h0;
            default: tol_pick = 64'h3E45_798E_E230_8C3A;
         endcase
         set_all($urandom_range(0, 3) == 0 ? {$urandom, $urandom} : tame_value(),
                 $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : tame_value(),
                 $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : tame_value(),
                 11'($urandom_range(0, 40)), tol_pick);
         no_gaps = (p % 3 == 1);
         for (int i = 0; i < 12; i++) send_item(random_z());
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[hypergeometric_1f2_series] OK");
      end else begin
         $display("[hypergeometric_1f2_series] ERROR");
      end
      $finish;
   end
endmodule
